@@ rtl/swu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swu_pkg
// Shared constants and types for the sliding-window UCB arm selector.
// ----------------------------------------------------------------------------
package swu_pkg;

    localparam int ARMS         = 8;
    localparam int ARM_W        = 3;
    localparam int WINDOW_DEPTH = 1024;
    localparam int PTR_W        = 10;
    localparam int CNT_W        = 11;
    localparam int CFG_W        = 24;
    localparam int DIV_W        = 44;
    localparam int LG_W         = 20;
    localparam int SQ_RES_W     = 22;
    localparam int SCORE_W      = 31;

    localparam logic [CNT_W-1:0] STEP_MAX  = 11'd2047;
    localparam logic [31:0]      LN2_Q32   = 32'd2977044472;

    typedef enum logic [1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_CONFIDENCE  = 2'd1,
        CFG_BOUND_SCALE = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVICT,
        S_APPEND,
        S_CHECK,
        S_LOG,
        S_LN,
        S_MEAN_INIT,
        S_MEAN_DIV,
        S_Q_DIV,
        S_SQRT,
        S_PAD,
        S_SCORE,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

@@ rtl/swu_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swu_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sliding_window_ucb_arm_select_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_ucb_arm_select_core
// Sliding-window UCB bandit: windowed reward history in RAM, per-arm
// counts and sums, sequenced Q16.16 score walk over all arms.
// ----------------------------------------------------------------------------
// Path to m_tvalid: idle, evict (when the window is full), append, check, then
// straight to the output during the warm-up steps and while an arm has no
// samples; otherwise 16 log squarings, then per arm a mean divide, confidence
// divide and isqrt. Throughput: one beat per result; the next beat is
// taken once the result is in the output register. Reset (aresetn low,
// synchronous) clears counts, sums, pointers and output valid and resets the
// step, configuration and sequencer; datapath and history RAM are not cleared.
module sliding_window_ucb_arm_select_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,     // [0] reward, [3:1] played_arm
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,     // [2:0] next_arm
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [23:0] cfg_wdata
);
    import swu_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] ws_reg;
    logic [CFG_W-1:0] conf_reg;
    logic [CFG_W-1:0] bound_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] cnt_arr [ARMS];
    logic [CNT_W-1:0] sum_arr [ARMS];

    logic             rew_reg;
    logic [ARM_W-1:0] arm_reg;
    logic [ARM_W-1:0] idx_reg;
    logic [4:0]       iter_reg;

    logic [30:0]        x_reg;
    logic [LG_W-1:0]    lg_reg;
    logic [LG_W-1:0]    ln_reg;
    logic [DIV_W-1:0]   prod_reg;
    logic [DIV_W-1:0]   dq_reg;
    logic [CNT_W-1:0]   dr_reg;
    logic [CNT_W-1:0]   dd_reg;
    logic [16:0]        mean_reg;
    logic [DIV_W-1:0]   sv_reg;
    logic [DIV_W-1:0]   sres_reg;
    logic [DIV_W-1:0]   sbit_reg;
    logic [29:0]        pad_reg;
    logic [SCORE_W-1:0] best_reg;
    logic [ARM_W-1:0]   best_arm_reg;
    logic [ARM_W-1:0]   result_reg;

    logic             m_tvalid_reg;
    logic [ARM_W-1:0] m_data_reg;

    // ring RAM
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [3:0]       ram_rdata;

    swu_ram #(.WIDTH(4), .DEPTH(WINDOW_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({arm_reg, rew_reg}),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] w_eff;
    logic             evict_need;
    logic [CNT_W-1:0] t_m1;
    logic             zero_found;
    logic [ARM_W-1:0] zero_idx;
    logic [CNT_W-1:0] n_val;
    logic [3:0]       k_val;
    logic [40:0]      n_shift;
    logic [ARM_W-1:0] cnt_addr;
    logic [CNT_W-1:0] cnt_rd;
    logic [CNT_W-1:0] sum_rd;
    logic [61:0]      sqr;
    logic [31:0]      sqr_sh;
    logic [3:0]       lg_bit;
    logic [51:0]      ln_prod;
    logic [DIV_W+CNT_W-1:0] div_nx;
    logic [DIV_W-1:0] sq_sum;
    logic [45:0]      pad_prod;
    logic [SCORE_W-1:0] score;
    logic             score_gt;
    logic [ARM_W-1:0] win_arm;
    logic [13:0]      cnt_total;

    assign w_eff = (ws_reg == '0) ? CNT_W'(1) :
                   (ws_reg > CNT_W'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH) : ws_reg;
    assign evict_need = (fill_reg >= w_eff) && (fill_reg != '0);
    assign t_m1  = step_reg - CNT_W'(1);
    assign n_val = (w_eff < step_reg) ? w_eff : step_reg;

    always_comb begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int a = ARMS - 1; a >= 0; a--) begin
            if (cnt_arr[a] == '0) begin
                zero_found = 1'b1;
                zero_idx   = ARM_W'(a);
            end
        end
    end

    always_comb begin
        k_val = '0;
        for (int b = 1; b < CNT_W; b++) begin
            if (n_val[b]) begin
                k_val = 4'(b);
            end
        end
    end

    assign n_shift = {n_val, 30'b0} >> k_val;

    always_comb begin
        case (state_reg)
            S_EVICT:  cnt_addr = ram_rdata[3:1];
            S_APPEND: cnt_addr = arm_reg;
            default:  cnt_addr = idx_reg;
        endcase
    end
    assign cnt_rd = cnt_arr[cnt_addr];
    assign sum_rd = sum_arr[cnt_addr];

    assign sqr     = {31'b0, x_reg} * {31'b0, x_reg};
    assign sqr_sh  = sqr[61:30];
    assign lg_bit  = 4'd15 - iter_reg[3:0];
    assign ln_prod = {32'b0, lg_reg} * {20'b0, LN2_Q32};

    // restoring divide, two quotient bits per cycle
    function automatic logic [DIV_W+CNT_W-1:0] div_step2(
        input logic [DIV_W-1:0] q_in,
        input logic [CNT_W-1:0] r_in,
        input logic [CNT_W-1:0] d
    );
        logic [DIV_W-1:0] q;
        logic [CNT_W-1:0] r;
        logic [CNT_W:0]   rs;
        logic [CNT_W:0]   diff;
        logic             ge;
        q = q_in;
        r = r_in;
        for (int i = 0; i < 2; i++) begin
            rs   = {r, q[DIV_W-1]};
            diff = rs - {1'b0, d};
            ge   = (rs >= {1'b0, d});
            r    = ge ? diff[CNT_W-1:0] : rs[CNT_W-1:0];
            q    = {q[DIV_W-2:0], ge};
        end
        return {q, r};
    endfunction

    assign div_nx   = div_step2(dq_reg, dr_reg, dd_reg);
    assign sq_sum   = sres_reg + sbit_reg;
    assign pad_prod = {22'b0, bound_reg} * {24'b0, sres_reg[SQ_RES_W-1:0]};
    assign score    = {14'b0, mean_reg} + {1'b0, pad_reg};
    assign score_gt = score > best_reg;
    assign win_arm  = score_gt ? idx_reg : best_arm_reg;

    always_comb begin
        cnt_total = '0;
        for (int a = 0; a < ARMS; a++) begin
            cnt_total = cnt_total + 14'(cnt_arr[a]);
        end
    end

    assign ram_we    = (state_reg == S_APPEND);
    assign ram_waddr = ptr_reg + fill_reg[PTR_W-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = evict_need ? S_EVICT : S_APPEND;
                end
            end
            S_EVICT:  state_next = S_APPEND;
            S_APPEND: state_next = S_CHECK;
            S_CHECK: begin
                if (t_m1 < CNT_W'(ARMS) || zero_found) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_LOG;
                end
            end
            S_LOG:       if (iter_reg == 5'd15) state_next = S_LN;
            S_LN:        state_next = S_MEAN_INIT;
            S_MEAN_INIT: state_next = S_MEAN_DIV;
            S_MEAN_DIV:  if (iter_reg == 5'd21) state_next = S_Q_DIV;
            S_Q_DIV:     if (iter_reg == 5'd21) state_next = S_SQRT;
            S_SQRT:      if (iter_reg == 5'd21) state_next = S_PAD;
            S_PAD:       state_next = S_SCORE;
            S_SCORE: begin
                state_next = (idx_reg == ARM_W'(ARMS - 1)) ? S_OUT : S_MEAN_INIT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg    <= CNT_W'(1024);
            conf_reg  <= CFG_W'(131072);
            bound_reg <= CFG_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WINDOW_SIZE: ws_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_CONFIDENCE:  conf_reg  <= cfg_wdata;
                CFG_BOUND_SCALE: bound_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // window state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            step_reg <= CNT_W'(1);
            for (int a = 0; a < ARMS; a++) begin
                cnt_arr[a] <= '0;
                sum_arr[a] <= '0;
            end
        end else begin
            case (state_reg)
                S_EVICT: begin
                    cnt_arr[cnt_addr] <= cnt_rd - CNT_W'(1);
                    sum_arr[cnt_addr] <= sum_rd - CNT_W'(ram_rdata[0]);
                    ptr_reg  <= ptr_reg + PTR_W'(1);
                    fill_reg <= fill_reg - CNT_W'(1);
                end
                S_APPEND: begin
                    cnt_arr[cnt_addr] <= cnt_rd + CNT_W'(1);
                    sum_arr[cnt_addr] <= sum_rd + CNT_W'(rew_reg);
                    fill_reg <= fill_reg + CNT_W'(1);
                    if (step_reg < STEP_MAX) begin
                        step_reg <= step_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // score datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                rew_reg <= s_tdata[0];
                arm_reg <= s_tdata[3:1];
            end
            S_CHECK: begin
                if (t_m1 < CNT_W'(ARMS)) begin
                    result_reg <= t_m1[ARM_W-1:0];
                end else begin
                    result_reg <= zero_idx;
                end
                x_reg        <= n_shift[30:0];
                lg_reg       <= {k_val, 16'b0};
                iter_reg     <= '0;
                idx_reg      <= '0;
                best_reg     <= '0;
                best_arm_reg <= '0;
            end
            S_LOG: begin
                if (sqr_sh[31]) begin
                    lg_reg[lg_bit] <= 1'b1;
                    x_reg          <= sqr_sh[31:1];
                end else begin
                    x_reg <= sqr_sh[30:0];
                end
                iter_reg <= iter_reg + 5'd1;
            end
            S_LN: begin
                ln_reg <= ln_prod[51:32];
            end
            S_MEAN_INIT: begin
                prod_reg <= {20'b0, conf_reg} * {24'b0, ln_reg};
                dq_reg   <= {17'b0, sum_rd, 16'b0};
                dr_reg   <= '0;
                dd_reg   <= cnt_rd;
                iter_reg <= '0;
            end
            S_MEAN_DIV: begin
                if (iter_reg == 5'd21) begin
                    mean_reg <= div_nx[CNT_W+16:CNT_W];
                    dq_reg   <= prod_reg;
                    dr_reg   <= '0;
                    iter_reg <= '0;
                end else begin
                    dq_reg   <= div_nx[DIV_W+CNT_W-1:CNT_W];
                    dr_reg   <= div_nx[CNT_W-1:0];
                    iter_reg <= iter_reg + 5'd1;
                end
            end
            S_Q_DIV: begin
                if (iter_reg == 5'd21) begin
                    sv_reg   <= div_nx[DIV_W+CNT_W-1:CNT_W];
                    sres_reg <= '0;
                    sbit_reg <= DIV_W'(1) << 42;
                    iter_reg <= '0;
                end else begin
                    dq_reg   <= div_nx[DIV_W+CNT_W-1:CNT_W];
                    dr_reg   <= div_nx[CNT_W-1:0];
                    iter_reg <= iter_reg + 5'd1;
                end
            end
            S_SQRT: begin
                if (sv_reg >= sq_sum) begin
                    sv_reg   <= sv_reg - sq_sum;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
                iter_reg <= iter_reg + 5'd1;
            end
            S_PAD: begin
                pad_reg <= pad_prod[45:16];
            end
            S_SCORE: begin
                if (score_gt) begin
                    best_reg <= score;
                end
                best_arm_reg <= win_arm;
                result_reg   <= win_arm;
                idx_reg      <= idx_reg + ARM_W'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_data_reg <= result_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_counts_match_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (cnt_total == {3'b0, fill_reg}))
        else $error("per-arm counts disagree with fill level");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("fill level beyond window depth");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer did not leave idle after input beat");

    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != '0)
        else $error("step index wrapped to zero");

endmodule
`default_nettype wire

@@ verif/sliding_window_ucb_arm_select_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_ucb_arm_select_core_tb
// Sends reward beats through the sliding-window UCB core and checks each
// selected arm against a cycle-free Q16.16 predictor kept in this bench.
// ----------------------------------------------------------------------------
module sliding_window_ucb_arm_select_core_tb;
    import swu_pkg::*;

    localparam int TIMEOUT_CYCLES = 3_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;

    sliding_window_ucb_arm_select_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [3:0]       hist [WINDOW_DEPTH];
    int unsigned      head_ptr, fill_lvl, step_cnt;
    int unsigned      arm_cnt [ARMS];
    int unsigned      arm_sum [ARMS];
    logic [10:0]      win_reg;
    logic [23:0]      conf_reg, bscale_reg;

    logic [ARM_W-1:0] arm_q [$];
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    int               burst_left = 0;

    function automatic longint unsigned ln_fixed(int unsigned n);
        int unsigned k;
        longint unsigned x, lg;
        k = 0;
        while (k < 31 && (n >> (k + 1)) != 0) k++;
        x = (longint'(n) << 30) >> k;
        lg = longint'(k) << 16;
        for (int i = 15; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                lg |= 64'd1 << i;
                x >>= 1;
            end
        end
        return (lg * 64'd2977044472) >> 32;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned eff_win();
        if (win_reg == 0) return 1;
        if (win_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
        return 32'(win_reg);
    endfunction

    function automatic logic [ARM_W-1:0] pick_arm();
        int unsigned n;
        longint unsigned lnv, best, mean, q, pad, score;
        logic [ARM_W-1:0] best_arm;
        n = (eff_win() < step_cnt) ? eff_win() : step_cnt;
        best = 0;
        best_arm = 0;
        if (step_cnt - 1 < ARMS) return ARM_W'(step_cnt - 1);
        for (int a = 0; a < ARMS; a++)
            if (arm_cnt[a] == 0) return ARM_W'(a);
        lnv = ln_fixed(n);
        for (int a = 0; a < ARMS; a++) begin
            mean = (longint'(arm_sum[a]) << 16) / arm_cnt[a];
            q = (longint'(conf_reg) * lnv) / arm_cnt[a];
            pad = (longint'(bscale_reg) * sqrt_floor(q)) >> 16;
            score = mean + pad;
            if (score > best) begin
                best = score;
                best_arm = ARM_W'(a);
            end
        end
        return best_arm;
    endfunction

    function automatic void record_reward(logic rwd, logic [ARM_W-1:0] arm);
        logic [3:0] old;
        if (fill_lvl >= eff_win() && fill_lvl > 0) begin
            old = hist[head_ptr];
            arm_cnt[old[3:1]]--;
            arm_sum[old[3:1]] -= 32'(old[0]);
            head_ptr = (head_ptr + 1) % WINDOW_DEPTH;
            fill_lvl--;
        end
        hist[(head_ptr + fill_lvl) % WINDOW_DEPTH] = {arm, rwd};
        fill_lvl++;
        arm_cnt[arm]++;
        arm_sum[arm] += 32'(rwd);
        if (step_cnt < STEP_MAX) step_cnt++;
        arm_q.push_back(pick_arm());
    endfunction

    // result checker
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (arm_q.size() == 0) begin
                $error("next_arm: no result expected, actual %0d", m_tdata[2:0]);
                err_cnt <= err_cnt + 1;
            end else begin
                if (m_tdata[2:0] !== arm_q[0]) begin
                    $error("next_arm: expected %0d actual %0d", arm_q[0], m_tdata[2:0]);
                    err_cnt <= err_cnt + 1;
                end
                void'(arm_q.pop_front());
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (cycle_cnt % 4000 < 1500) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("sliding_window_ucb_arm_select_core_tb: done, errors");
            $finish;
        end
    end

    // tvalid stays high across a burst and drops at its end
    task automatic send_beat(logic rwd, logic [ARM_W-1:0] arm);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, arm, rwd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        record_reward(rwd, arm);
        @(negedge aclk);
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    task automatic end_burst();
        if (burst_left != 0) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic drain();
        end_burst();
        while (arm_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        end_burst();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WINDOW_SIZE: win_reg = val[10:0];
            CFG_CONFIDENCE:  conf_reg = val;
            default:         bscale_reg = val;
        endcase
    endtask

    task automatic test_warmup();
        // warm-up steps, all arms, both reward values and arm extremes
        for (int i = 0; i < 8; i++) send_beat(i[0], ARM_W'(i));
        send_beat(1'b1, 3'd7);
        send_beat(1'b0, 3'd0);
        drain();
    endtask

    task automatic test_small_window();
        // tiny window empties arms; zero acts as one; shrink while full
        write_reg(CFG_WINDOW_SIZE, 24'd0);
        for (int i = 0; i < 4; i++) send_beat(1'b1, 3'd7);
        drain();
        write_reg(CFG_WINDOW_SIZE, 24'd1);
        send_beat(1'b0, 3'd3);
        drain();
        write_reg(CFG_WINDOW_SIZE, 24'd16);
        for (int i = 0; i < 20; i++) send_beat(1'($urandom_range(0, 1)), ARM_W'(i));
        drain();
        write_reg(CFG_WINDOW_SIZE, 24'd9);
        for (int i = 0; i < 6; i++) send_beat(1'b1, ARM_W'(i));
        drain();
    endtask

    task automatic test_random(int n_items);
        logic [ARM_W-1:0] fav;
        fav = ARM_W'($urandom);
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 149) begin
                drain();
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_WINDOW_SIZE, 24'($urandom_range(8, 40)));
                    1: write_reg(CFG_WINDOW_SIZE, 24'd2047);
                    2: write_reg(CFG_CONFIDENCE, 24'hFFFFFF);
                    3: write_reg(CFG_BOUND_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
                    default: write_reg(CFG_CONFIDENCE, 24'd0);
                endcase
            end
            if ($urandom_range(0, 3) == 0) fav = ARM_W'($urandom);
            send_beat(($urandom_range(0, 2) != 0),
                      ($urandom_range(0, 1) != 0) ? fav : ARM_W'($urandom));
        end
        drain();
    endtask

    task automatic test_registers_extremes();
        write_reg(CFG_BOUND_SCALE, 24'd0);
        write_reg(CFG_CONFIDENCE, 24'd0);
        for (int i = 0; i < 12; i++) send_beat(1'b0, ARM_W'(i));
        drain();
        write_reg(CFG_BOUND_SCALE, 24'hFFFFFF);
        write_reg(CFG_CONFIDENCE, 24'hFFFFFF);
        write_reg(CFG_WINDOW_SIZE, 24'd1024);
        for (int i = 0; i < 12; i++) send_beat(1'b1, ARM_W'(i * 3));
        drain();
    endtask

    initial begin
        head_ptr = 0;
        fill_lvl = 0;
        step_cnt = 1;
        for (int a = 0; a < ARMS; a++) begin
            arm_cnt[a] = 0;
            arm_sum[a] = 0;
        end
        win_reg = 11'd1024;
        conf_reg = 24'd131072;
        bscale_reg = 24'd65536;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_warmup();
        test_small_window();
        test_registers_extremes();
        write_reg(CFG_CONFIDENCE, 24'd131072);
        write_reg(CFG_BOUND_SCALE, 24'd65536);
        test_random(535);
        repeat (50) @(negedge aclk);
        if (err_cnt == 0 && arm_q.size() == 0) begin
            $display("sliding_window_ucb_arm_select_core_tb: done, clean");
        end else begin
            $display("sliding_window_ucb_arm_select_core_tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
